// ----- hw/rtl/iafyz_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafyz_pkg
// Shared constants and types of the angle frame parser with yaw zeroing.
// ----------------------------------------------------------------------------
package iafyz_pkg;

  // Frame layout.
  localparam logic [7:0] Hdr0      = 8'h55;
  localparam logic [7:0] Hdr1      = 8'h53;
  localparam logic [3:0] IdxYawLo  = 4'd6;
  localparam logic [3:0] IdxYawHi  = 4'd7;
  localparam logic [3:0] IdxCsum   = 4'd10;

  // Calibration: number of frames averaged into the zero offset (1 to 15).
  localparam int unsigned CalibFrames = 10;
  localparam int unsigned CalibCntW   = $clog2(CalibFrames + 1);
  localparam int unsigned CalibHalf   = CalibFrames / 2;

  // Offset accumulator and the reciprocal that divides it by CalibFrames.
  // With the shift at OffsetW plus the divisor's bit count, the rounded-up
  // reciprocal gives the exact floor for every operand below 2**OffsetW.
  localparam int unsigned OffsetW    = 21;
  localparam int unsigned RecipShift = OffsetW + $clog2(CalibFrames);
  localparam int unsigned RecipMul   = ((1 << RecipShift) + CalibFrames - 1) / CalibFrames;
  localparam int unsigned RecipW     = $clog2(RecipMul + 1);

  // Queue between the parser and the zeroing stage.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic               push;
    logic signed [15:0] yaw;
  } yaw_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    ST_CALIB = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_RUN   = 4'b1000
  } zero_state_e;

endpackage

// ----- hw/rtl/imu_angle_frame_yaw_zeroing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_angle_frame_yaw_zeroing
// Parses angle frames from a serial byte stream and outputs yaw relative to
// the mean of the first calibration frames.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained; the parser stalls only on a full
// yaw queue.
// Flow: a yaw is queued on acceptance of its checksum byte, then popped into
// the output register. After calibration the mean is formed by a load of the
// rounded magnitude, then one reciprocal multiply; frames wait queued.
// Reset: asynchronous, active low, clears all control state; no clear pass.
module imu_angle_frame_yaw_zeroing
  import iafyz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] rel_yaw
);

  yaw_push_t          yaw_push;
  fifo_stat_t         fifo_stat;
  logic               pop;
  logic signed [15:0] yaw_head;

  iafyz_frame_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .fifo_stat_i  (fifo_stat),
    .byte_ready_o (s_axis_tready),
    .yaw_push_o   (yaw_push)
  );

  iafyz_yaw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .yaw_push_i  (yaw_push),
    .pop_i       (pop),
    .yaw_o       (yaw_head),
    .fifo_stat_o (fifo_stat)
  );

  iafyz_zeroing u_zeroing (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .yaw_i       (yaw_head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rel_yaw_o   (m_axis_tdata)
  );

endmodule

// ----- hw/rtl/iafyz_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafyz_frame_parser
// Hunts for angle frames in the byte stream and pushes the yaw of each frame
// whose checksum matches.
// ----------------------------------------------------------------------------
module iafyz_frame_parser
  import iafyz_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       byte_ready_o,
  output yaw_push_t  yaw_push_o
);

  logic       in_frame_q, in_frame_d;
  logic [3:0] byte_cnt_q, byte_cnt_d;
  logic [7:0] csum_q, csum_d;
  logic [7:0] yaw_lo_q, yaw_lo_d;
  logic [7:0] yaw_hi_q, yaw_hi_d;
  logic       accept;
  logic       push;

  // Only the checksum byte pushes, so holding off on a full queue is enough.
  assign byte_ready_o = !fifo_stat_i.full;
  assign accept       = byte_valid_i && byte_ready_o;

  always_comb begin
    in_frame_d = in_frame_q;
    byte_cnt_d = byte_cnt_q;
    csum_d     = csum_q;
    yaw_lo_d   = yaw_lo_q;
    yaw_hi_d   = yaw_hi_q;
    push       = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (byte_i == Hdr0) begin
          in_frame_d = 1'b1;
          byte_cnt_d = 4'd1;
          csum_d     = byte_i;
        end
      end else if (byte_cnt_q <= 4'd1) begin
        // A bad second byte drops the frame and is never a new start.
        if (byte_i != Hdr1) begin
          in_frame_d = 1'b0;
          byte_cnt_d = '0;
          csum_d     = '0;
        end else begin
          csum_d     = csum_q + byte_i;
          byte_cnt_d = byte_cnt_q + 4'd1;
        end
      end else if (byte_cnt_q >= IdxCsum) begin
        push       = (byte_i == csum_q);
        in_frame_d = 1'b0;
        byte_cnt_d = '0;
        csum_d     = '0;
      end else begin
        if (byte_cnt_q == IdxYawLo) begin
          yaw_lo_d = byte_i;
        end
        if (byte_cnt_q == IdxYawHi) begin
          yaw_hi_d = byte_i;
        end
        csum_d     = csum_q + byte_i;
        byte_cnt_d = byte_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      byte_cnt_q <= '0;
      csum_q     <= '0;
      yaw_lo_q   <= '0;
      yaw_hi_q   <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      byte_cnt_q <= byte_cnt_d;
      csum_q     <= csum_d;
      yaw_lo_q   <= yaw_lo_d;
      yaw_hi_q   <= yaw_hi_d;
    end
  end

  assign yaw_push_o.push = push;
  assign yaw_push_o.yaw  = $signed({yaw_hi_q, yaw_lo_q});

endmodule

// ----- hw/rtl/iafyz_yaw_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafyz_yaw_fifo
// Short queue of yaw values between the frame parser and the zeroing stage.
// ----------------------------------------------------------------------------
module iafyz_yaw_fifo
  import iafyz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  yaw_push_t          yaw_push_i,
  input  logic               pop_i,
  output logic signed [15:0] yaw_o,
  output fifo_stat_t         fifo_stat_o
);

  logic signed [15:0]  mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign fifo_stat_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign fifo_stat_o.empty = (cnt_q == '0);
  assign do_push = yaw_push_i.push && !fifo_stat_o.full;
  assign do_pop  = pop_i && !fifo_stat_o.empty;
  assign yaw_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= yaw_push_i.yaw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTH
  a_cnt_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != FifoCntW'(FifoDepth)) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue count disagrees with pointers");
`endif

endmodule

// ----- hw/rtl/iafyz_zeroing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iafyz_zeroing
// Sums the calibration frames, forms the rounded mean offset by a reciprocal
// multiplication and subtracts it from every later yaw.
// ----------------------------------------------------------------------------
module iafyz_zeroing
  import iafyz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] yaw_i,
  input  fifo_stat_t         fifo_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        rel_yaw_o
);

  zero_state_e               state_q, state_d;
  logic [CalibCntW-1:0]      calib_cnt_q, calib_cnt_d;
  logic [OffsetW-1:0]        offset_q, offset_d;
  logic [OffsetW-1:0]        quo_q, quo_d;
  logic                      neg_q, neg_d;
  logic [15:0]               mean_q, mean_d;
  logic                      out_valid_q, out_valid_d;
  logic [15:0]               rel_yaw_q, rel_yaw_d;
  logic [OffsetW-1:0]        mag;
  logic [OffsetW+RecipW-1:0] prod;
  logic [15:0]               mean_mag;

  assign mag      = offset_q[OffsetW-1] ? (~offset_q + 1'b1) : offset_q;
  assign prod     = quo_q * RecipW'(RecipMul);
  assign mean_mag = prod[RecipShift +: 16];

  always_comb begin
    state_d     = state_q;
    calib_cnt_d = calib_cnt_q;
    offset_d    = offset_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    mean_d      = mean_q;
    out_valid_d = out_valid_q;
    rel_yaw_d   = rel_yaw_q;
    pop_o       = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CALIB: begin
        if (!fifo_stat_i.empty) begin
          pop_o       = 1'b1;
          offset_d    = offset_q + OffsetW'(yaw_i);
          calib_cnt_d = calib_cnt_q + 1'b1;
          if (calib_cnt_d == CalibCntW'(CalibFrames)) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        neg_d   = offset_q[OffsetW-1];
        quo_d   = mag + OffsetW'(CalibHalf);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // The rounded magnitude times the reciprocal, shifted down, is the mean's magnitude.
        mean_d  = neg_q ? (~mean_mag + 1'b1) : mean_mag;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (!fifo_stat_i.empty && (!out_valid_q || out_ready_i)) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          rel_yaw_d   = yaw_i - mean_q;
        end
      end
      default: begin
        state_d = ST_CALIB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CALIB;
      calib_cnt_q <= '0;
      offset_q    <= '0;
      neg_q       <= 1'b0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      calib_cnt_q <= calib_cnt_d;
      offset_q    <= offset_d;
      neg_q       <= neg_d;
      mean_q      <= mean_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rel_yaw_q <= rel_yaw_d;
  end

  assign out_valid_o = out_valid_q;
  assign rel_yaw_o   = rel_yaw_q;

`ifndef SYNTH
  a_no_result_before_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !out_valid_q)
    else $error("result shown before the offset is known");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && state_q == ST_RUN) |=> out_valid_q)
    else $error("popped yaw did not reach the output register");

  a_calib_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CALIB) |-> (calib_cnt_q == CalibCntW'(CalibFrames)))
    else $error("calibration left with a wrong frame count");
`endif

endmodule

// ----- verif/tb_imu_angle_frame_yaw_zeroing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_angle_frame_yaw_zeroing
// Self-checking bench for the angle frame parser with yaw zeroing. Serial
// bytes are streamed in with random bursts and gaps. A byte-level tracker of
// the frame hunt, the checksum and the calibration offset predicts each
// zeroed yaw, and every output request is checked against the oldest
// prediction. The output side stalls on its own patterns, including one long
// hold-off that fills the internal queue.
// ----------------------------------------------------------------------------
module tb_imu_angle_frame_yaw_zeroing;
  import iafyz_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned RandomBytes   = 180;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] rel_yaw

  imu_angle_frame_yaw_zeroing dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Tracked parser and calibration state.
  bit          frm_active;
  logic [3:0]  frm_idx;
  logic [7:0]  frm_sum;
  logic [7:0]  yaw_lo;
  logic [7:0]  yaw_hi;
  int unsigned calib_seen;
  int          offset_acc;

  logic [15:0] rel_yaw_q [$];
  logic [15:0] want_yaw;
  int unsigned err_cnt;
  int unsigned stall_cycles;
  int unsigned burst_left;
  int unsigned hold_cycles_req;
  rx_mode_e    rx_mode;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Follows one accepted byte through the frame hunt and queues the zeroed
  // yaw when a valid frame completes after calibration.
  function automatic void track_rx_byte(logic [7:0] b);
    logic signed [15:0] yaw;
    int mag;
    int mean;
    int diff;
    if (!frm_active) begin
      if (b == Hdr0) begin
        frm_active = 1'b1;
        frm_idx    = 4'd1;
        frm_sum    = b;
      end
    end else if (frm_idx == 4'd1 && b != Hdr1) begin
      // The failing byte is dropped, even when it is another header byte.
      frm_active = 1'b0;
    end else if (frm_idx == IdxCsum) begin
      frm_active = 1'b0;
      if (b == frm_sum) begin
        yaw = {yaw_hi, yaw_lo};
        if (calib_seen < CalibFrames) begin
          calib_seen++;
          offset_acc += int'(yaw);
        end else begin
          mag  = (offset_acc < 0) ? -offset_acc : offset_acc;
          mean = (mag + int'(CalibFrames / 2)) / int'(CalibFrames);
          if (offset_acc < 0) mean = -mean;
          diff = int'(yaw) - mean;
          rel_yaw_q.push_back(16'(diff));
        end
      end
    end else begin
      if (frm_idx == IdxYawLo) yaw_lo = b;
      if (frm_idx == IdxYawHi) yaw_hi = b;
      frm_sum = frm_sum + b;
      frm_idx = frm_idx + 4'd1;
    end
  endfunction

  // Called and returns at a falling edge. Bursts of random length are
  // separated by random idle gaps, which may be empty.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_rx_byte(b);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Sends one angle frame. A negative fill value gives random data bytes.
  task automatic send_frame(input logic [15:0] yaw, input bit bad_csum, input int fill);
    logic [7:0] fb [11];
    logic [7:0] sum;
    sum = 8'd0;
    for (int i = 0; i < 11; i++) begin
      if (i == 0) fb[i] = Hdr0;
      else if (i == 1) fb[i] = Hdr1;
      else if (i == IdxYawLo) fb[i] = yaw[7:0];
      else if (i == IdxYawHi) fb[i] = yaw[15:8];
      else if (i == IdxCsum) fb[i] = bad_csum ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
      else fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i < IdxCsum) sum = sum + fb[i];
    end
    for (int i = 0; i < 11; i++) send_byte(fb[i]);
  endtask

  task automatic test_stray_bytes();
    rx_mode = RX_ALWAYS;
    // Bytes outside a frame other than the first header byte are ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(Hdr1);
    send_byte(8'hAA);
    // A second header byte in place of the frame type must not restart.
    send_byte(Hdr0);
    send_byte(Hdr0);
    send_byte(Hdr1);
    send_byte(Hdr0);
    send_byte(8'h00);
  endtask

  task automatic test_calibration();
    logic [15:0] cal_yaw [10];
    cal_yaw = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
                16'h0001, 16'hFFFF, 16'd100, -16'sd12443, 16'h0000};
    rx_mode = RX_COIN;
    for (int i = 0; i < int'(CalibFrames); i++) begin
      // Dropped frames in between must leave the offset untouched.
      if (i == 2) send_frame(16'h1234, 1'b1, 8'h55);
      if (i == 5) send_frame(16'h7FFF, 1'b1, -1);
      send_frame(cal_yaw[i % 10], 1'b0, (i == 1) ? 8'h55 : (i == 3) ? 8'hFF : -1);
    end
  endtask

  task automatic test_zeroed_extremes();
    rx_mode = RX_ALWAYS;
    send_frame(16'h7FFF, 1'b0, 8'h55);
    send_frame(16'h8000, 1'b0, 8'h00);
    send_frame(16'h0000, 1'b0, 8'hFF);
    send_frame(-16'sd1235, 1'b0, -1);
    send_frame(16'd31532, 1'b0, -1);
    send_frame(16'h4321, 1'b1, -1);
    send_frame(-16'sd1236, 1'b0, -1);
  endtask

  task automatic test_backpressure();
    rx_mode = RX_ALWAYS;
    hold_cycles_req = 300;
    for (int i = 0; i < 14; i++) send_frame(16'($urandom), 1'b0, -1);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    logic [15:0] yaw;
    sent = 0;
    while (sent < RandomBytes) begin
      if ($urandom_range(0, 14) == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        yaw = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000)
                                          : 16'($urandom);
        send_frame(yaw, 1'b0, -1);
        sent += 11;
      end else if (pick < 88) begin
        send_frame(16'($urandom), 1'b1, -1);
        sent += 11;
      end else if (pick < 93) begin
        // Cut-off frame: the bytes that follow are taken as its tail.
        n = $urandom_range(0, 7);
        send_byte(Hdr0);
        send_byte(Hdr1);
        repeat (n) send_byte(8'($urandom));
        sent += 2 + n;
      end else if (pick < 97) begin
        b = 8'($urandom);
        if (b == Hdr1) b = Hdr0;
        send_byte(Hdr0);
        send_byte(b);
        sent += 2;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
        sent += n;
      end
    end
  endtask

  // Output side: its own stall patterns and a long hold-off on request.
  initial begin
    int unsigned held;
    int unsigned phase;
    m_axis_tready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles_req != 0) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < hold_cycles_req) begin
          @(negedge clk_i);
          held++;
        end
        hold_cycles_req = 0;
      end
      phase++;
      case (rx_mode)
        RX_ALWAYS:   m_axis_tready <= 1'b1;
        RX_COIN:     m_axis_tready <= ($urandom_range(0, 2) != 0);
        default:     m_axis_tready <= (phase % 7) < 4;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rel_yaw_q.size() == 0) begin
        $display("%0t: rel_yaw %0d with no request expected", $time, $signed(m_axis_tdata));
        err_cnt++;
      end else begin
        want_yaw = rel_yaw_q.pop_front();
        if (m_axis_tdata !== want_yaw) begin
          $display("%0t: rel_yaw expected %0d, got %0d", $time,
                   $signed(want_yaw), $signed(m_axis_tdata));
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    rx_mode         = RX_ALWAYS;
    hold_cycles_req = 0;
    burst_left      = 0;
    err_cnt         = 0;
    stall_cycles    = 0;
    frm_active      = 1'b0;
    frm_idx         = 4'd0;
    frm_sum         = 8'd0;
    yaw_lo          = 8'd0;
    yaw_hi          = 8'd0;
    calib_seen      = 0;
    offset_acc      = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_stray_bytes();
    test_calibration();
    test_zeroed_extremes();
    test_backpressure();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    while (rel_yaw_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/iafyz_pkg.sv
hw/rtl/iafyz_frame_parser.sv
hw/rtl/iafyz_yaw_fifo.sv
hw/rtl/iafyz_zeroing.sv
hw/rtl/imu_angle_frame_yaw_zeroing.sv
verif/tb_imu_angle_frame_yaw_zeroing.sv
